// ===== sv/qod_pkg.sv =====
// Shared types, constants and helper functions for the quadratic outline decomposer.
// Depends on nothing; every other file of the block refers to it by scoped names.

package qod_pkg;

  localparam int COORD_BITS = 24;
  localparam int MAX_SEGS = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [1:0] seg_count_t;

  typedef enum logic [1:0] {
    KIND_MOVE  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_CURVE = 2'd2,
    KIND_CLOSE = 2'd3
  } seg_kind_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   on_curve;
    logic   contour_end;
  } point_word_t;

  typedef struct packed {
    seg_kind_t segment_kind;
    coord_t    control_x;
    coord_t    control_y;
    coord_t    anchor_x;
    coord_t    anchor_y;
    logic      last_result;
  } segment_word_t;

  typedef struct packed {
    seg_count_t                   count;
    segment_word_t [MAX_SEGS-1:0] segs;
  } seg_bundle_t;

  function automatic coord_t midpoint(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] diff;
    logic signed [COORD_BITS:0] biased;
    logic signed [COORD_BITS:0] half;
    logic signed [COORD_BITS:0] sum;
    diff   = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
    biased = diff + {{COORD_BITS{1'b0}}, diff[COORD_BITS]};
    half   = biased >>> 1;
    sum    = {a[COORD_BITS-1], a} + half;
    return sum[COORD_BITS-1:0];
  endfunction

  function automatic segment_word_t make_seg(seg_kind_t kind, coord_t cx, coord_t cy,
                                             coord_t ax, coord_t ay);
    segment_word_t s;
    s.segment_kind = kind;
    s.control_x    = cx;
    s.control_y    = cy;
    s.anchor_x     = ax;
    s.anchor_y     = ay;
    s.last_result  = 1'b0;
    return s;
  endfunction

endpackage

// ===== sv/qod_step.sv =====
// Contour state and per-point segment generation for the outline decomposer.
// Depends on qod_pkg for the word, segment and bundle types.

module qod_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  qod_pkg::point_word_t point,
  output qod_pkg::seg_bundle_t bundle
);

  qod_pkg::coord_t start_x;
  qod_pkg::coord_t start_y;
  qod_pkg::coord_t pending_ctrl_x;
  qod_pkg::coord_t pending_ctrl_y;
  logic            pending_valid;
  logic            inside_contour;

  qod_pkg::coord_t start_x_next;
  qod_pkg::coord_t start_y_next;
  qod_pkg::coord_t pending_ctrl_x_next;
  qod_pkg::coord_t pending_ctrl_y_next;
  logic            pending_valid_next;
  logic            inside_contour_next;

  qod_pkg::coord_t       pcx1;
  qod_pkg::coord_t       pcy1;
  logic                  pv1;
  logic                  have_first;
  qod_pkg::segment_word_t first_seg;
  qod_pkg::segment_word_t tail_seg;
  qod_pkg::segment_word_t close_seg;

  always_comb begin
    start_x_next = start_x;
    start_y_next = start_y;
    pv1          = pending_valid;
    pcx1         = pending_ctrl_x;
    pcy1         = pending_ctrl_y;
    have_first   = 1'b0;
    first_seg    = qod_pkg::make_seg(qod_pkg::KIND_CURVE, pending_ctrl_x, pending_ctrl_y,
                                     qod_pkg::midpoint(pending_ctrl_x, point.point_x),
                                     qod_pkg::midpoint(pending_ctrl_y, point.point_y));
    if (!inside_contour) begin
      start_x_next = point.point_x;
      start_y_next = point.point_y;
      pv1          = 1'b0;
      pcx1         = '0;
      pcy1         = '0;
      have_first   = 1'b1;
      first_seg    = qod_pkg::make_seg(qod_pkg::KIND_MOVE, '0, '0, point.point_x,
                                       point.point_y);
    end else if (point.on_curve) begin
      have_first = 1'b1;
      if (pending_valid) begin
        first_seg = qod_pkg::make_seg(qod_pkg::KIND_CURVE, pending_ctrl_x, pending_ctrl_y,
                                      point.point_x, point.point_y);
      end else begin
        first_seg = qod_pkg::make_seg(qod_pkg::KIND_LINE, '0, '0, point.point_x,
                                      point.point_y);
      end
      pv1  = 1'b0;
      pcx1 = '0;
      pcy1 = '0;
    end else begin
      have_first = pending_valid;
      pv1        = 1'b1;
      pcx1       = point.point_x;
      pcy1       = point.point_y;
    end

    if (pv1) begin
      tail_seg = qod_pkg::make_seg(qod_pkg::KIND_CURVE, pcx1, pcy1, start_x_next,
                                   start_y_next);
    end else begin
      tail_seg = qod_pkg::make_seg(qod_pkg::KIND_LINE, '0, '0, start_x_next, start_y_next);
    end
    close_seg             = qod_pkg::make_seg(qod_pkg::KIND_CLOSE, '0, '0, '0, '0);
    close_seg.last_result = 1'b1;

    if (point.contour_end) begin
      if (have_first) begin
        bundle.count   = 2'd3;
        bundle.segs[0] = first_seg;
        bundle.segs[1] = tail_seg;
        bundle.segs[2] = close_seg;
      end else begin
        bundle.count   = 2'd2;
        bundle.segs[0] = tail_seg;
        bundle.segs[1] = close_seg;
        bundle.segs[2] = close_seg;
      end
      pending_valid_next  = 1'b0;
      pending_ctrl_x_next = '0;
      pending_ctrl_y_next = '0;
      inside_contour_next = 1'b0;
    end else begin
      bundle.count               = have_first ? 2'd1 : 2'd0;
      bundle.segs[0]             = first_seg;
      bundle.segs[0].last_result = 1'b1;
      bundle.segs[1]             = close_seg;
      bundle.segs[2]             = close_seg;
      pending_valid_next         = pv1;
      pending_ctrl_x_next        = pcx1;
      pending_ctrl_y_next        = pcy1;
      inside_contour_next        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x        <= '0;
      start_y        <= '0;
      pending_ctrl_x <= '0;
      pending_ctrl_y <= '0;
      pending_valid  <= 1'b0;
      inside_contour <= 1'b0;
    end else if (load) begin
      start_x        <= start_x_next;
      start_y        <= start_y_next;
      pending_ctrl_x <= pending_ctrl_x_next;
      pending_ctrl_y <= pending_ctrl_y_next;
      pending_valid  <= pending_valid_next;
      inside_contour <= inside_contour_next;
    end
  end

endmodule

// ===== sv/qod_out_queue.sv =====
// Segment buffer and output register of the outline decomposer.
// Depends on qod_pkg for the segment and bundle types.

module qod_out_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  qod_pkg::seg_bundle_t   bundle,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_stall,
  output qod_pkg::segment_word_t out_word
);

  qod_pkg::seg_count_t                            rem;
  qod_pkg::segment_word_t [qod_pkg::MAX_SEGS-1:0] segs;

  logic o_load;
  logic pop;

  assign o_load = !out_valid || !out_stall;
  assign pop    = o_load && (rem != 2'd0);
  assign room   = (rem == 2'd0) || ((rem == 2'd1) && o_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (o_load) begin
        out_valid <= (rem != 2'd0);
      end
      if (load) begin
        rem <= bundle.count;
      end else if (pop) begin
        rem <= rem - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= segs[0];
    end
    if (load) begin
      segs <= bundle.segs;
    end else if (pop) begin
      segs[0] <= segs[1];
      segs[1] <= segs[2];
    end
  end

endmodule

// ===== sv/quadratic_outline_decomposer_top.sv =====
// Top level of the quadratic outline decomposer: point words in, segment words out.
// Depends on qod_pkg, qod_step and qod_out_queue.
//
//   channel   direction  handshake              word type
//   in_word   input      in_valid / in_stall    qod_pkg::point_word_t
//   out_word  output     out_valid / out_stall  qod_pkg::segment_word_t
//
// A point is decoded in the cycle it is taken and its segments are registered in the segment
// buffer, then in the output register. A point giving zero or one segment is taken every
// cycle while the output is not stalled; a contour end gives up to three segments, which
// leave the three-entry segment buffer one a cycle while unstalled, so the input is held
// until the last of them leaves. Reset is synchronous and holds in_stall high while asserted.
// An output stall holds the output register, and holds the input while any segment is buffered.

module quadratic_outline_decomposer_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  qod_pkg::point_word_t   in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output qod_pkg::segment_word_t out_word
);

  logic                 accept;
  logic                 room;
  qod_pkg::seg_bundle_t bundle;

  assign in_stall = rst || !room;
  assign accept   = in_valid && !in_stall;

  qod_step u_step (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .point  (in_word),
    .bundle (bundle)
  );

  qod_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .bundle    (bundle),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== sv/qod_checker.sv =====
// Port-level checks for the quadratic outline decomposer, bound to its top level.
// Depends on qod_pkg and quadratic_outline_decomposer_top.

module qod_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input qod_pkg::point_word_t   in_word,
  input logic                   out_valid,
  input logic                   out_stall,
  input qod_pkg::segment_word_t out_word
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("Stalled input word changed.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("Stalled output word changed.");

  a_close_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.segment_kind == qod_pkg::KIND_CLOSE) |-> out_word.last_result)
    else $error("Close segment is not the last of its point.");

  a_close_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.segment_kind == qod_pkg::KIND_CLOSE) |->
      (out_word.anchor_x == '0) && (out_word.anchor_y == '0) &&
      (out_word.control_x == '0) && (out_word.control_y == '0))
    else $error("Close segment carries coordinates.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid straight after reset.");

endmodule

bind quadratic_outline_decomposer_top qod_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for quadratic_outline_decomposer_top: outline point words are sent
// in, and every segment word is checked against a predictor of the contour decomposition.
// Depends on qod_pkg and the block's RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 60000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  qod_pkg::point_word_t   in_word = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  qod_pkg::segment_word_t out_word;

  qod_pkg::segment_word_t expected_segments[$];
  int                     error_count = 0;
  int                     cycle_count = 0;
  int                     stall_left = 0;
  bit                     no_idling = 1'b0;

  // Predictor copy of the contour state.
  qod_pkg::coord_t        anchor_x = '0;
  qod_pkg::coord_t        anchor_y = '0;
  qod_pkg::coord_t        ctrl_x = '0;
  qod_pkg::coord_t        ctrl_y = '0;
  bit                     ctrl_held = 1'b0;
  bit                     in_contour = 1'b0;

  quadratic_outline_decomposer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int draw_wait();
    if (no_idling) return 0;
    return $urandom_range(0, 4);
  endfunction

  function automatic qod_pkg::coord_t half_way(qod_pkg::coord_t a, qod_pkg::coord_t b);
    longint          sa;
    longint          sb;
    qod_pkg::coord_t r;
    sa = a;
    sb = b;
    r = qod_pkg::coord_t'(sa + (sb - sa) / 2);
    return r;
  endfunction

  function automatic qod_pkg::segment_word_t build_segment(qod_pkg::seg_kind_t kind,
                                                           qod_pkg::coord_t cx,
                                                           qod_pkg::coord_t cy,
                                                           qod_pkg::coord_t ax,
                                                           qod_pkg::coord_t ay);
    qod_pkg::segment_word_t s;
    s.segment_kind = kind;
    s.control_x    = cx;
    s.control_y    = cy;
    s.anchor_x     = ax;
    s.anchor_y     = ay;
    s.last_result  = 1'b0;
    return s;
  endfunction

  function automatic qod_pkg::point_word_t make_point(int x, int y, bit on, bit last);
    qod_pkg::point_word_t p;
    p.point_x     = qod_pkg::coord_t'(x);
    p.point_y     = qod_pkg::coord_t'(y);
    p.on_curve    = on;
    p.contour_end = last;
    return p;
  endfunction

  function automatic int rand_coord();
    qod_pkg::coord_t c;
    case ($urandom_range(0, 9))
      0: c = {1'b0, {(qod_pkg::COORD_BITS-1){1'b1}}};
      1: c = {1'b1, {(qod_pkg::COORD_BITS-1){1'b0}}};
      2, 3, 4: c = qod_pkg::coord_t'(int'($urandom_range(0, 256)) - 128);
      default: c = qod_pkg::coord_t'($urandom);
    endcase
    return c;
  endfunction

  task automatic predict_segments(qod_pkg::point_word_t p);
    qod_pkg::segment_word_t segs[$];
    qod_pkg::coord_t        px;
    qod_pkg::coord_t        py;
    px = p.point_x;
    py = p.point_y;
    if (!in_contour) begin
      anchor_x   = px;
      anchor_y   = py;
      ctrl_held  = 1'b0;
      ctrl_x     = '0;
      ctrl_y     = '0;
      in_contour = 1'b1;
      segs.push_back(build_segment(qod_pkg::KIND_MOVE, '0, '0, px, py));
    end else if (p.on_curve) begin
      if (ctrl_held) begin
        segs.push_back(build_segment(qod_pkg::KIND_CURVE, ctrl_x, ctrl_y, px, py));
      end else begin
        segs.push_back(build_segment(qod_pkg::KIND_LINE, '0, '0, px, py));
      end
      ctrl_held = 1'b0;
      ctrl_x    = '0;
      ctrl_y    = '0;
    end else begin
      if (ctrl_held) begin
        segs.push_back(build_segment(qod_pkg::KIND_CURVE, ctrl_x, ctrl_y,
                                     half_way(ctrl_x, px), half_way(ctrl_y, py)));
      end
      ctrl_x    = px;
      ctrl_y    = py;
      ctrl_held = 1'b1;
    end
    if (p.contour_end) begin
      if (ctrl_held) begin
        segs.push_back(build_segment(qod_pkg::KIND_CURVE, ctrl_x, ctrl_y, anchor_x,
                                     anchor_y));
      end else begin
        segs.push_back(build_segment(qod_pkg::KIND_LINE, '0, '0, anchor_x, anchor_y));
      end
      segs.push_back(build_segment(qod_pkg::KIND_CLOSE, '0, '0, '0, '0));
      ctrl_held  = 1'b0;
      ctrl_x     = '0;
      ctrl_y     = '0;
      in_contour = 1'b0;
    end
    if (segs.size() > 0) segs[segs.size()-1].last_result = 1'b1;
    foreach (segs[i]) expected_segments.push_back(segs[i]);
  endtask

  // Called at a rising edge; returns at the edge that takes the word.
  task automatic send_point(qod_pkg::point_word_t p);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= p;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_segments(p);
  endtask

  task automatic note_field(string name, int expv, int actv);
    if (expv != actv) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, expv, actv);
      error_count++;
    end
  endtask

  task automatic check_segment(qod_pkg::segment_word_t got);
    qod_pkg::segment_word_t want;
    if (expected_segments.size() == 0) begin
      $display("%0t: unexpected segment word, kind %0d anchor (%0d, %0d)", $time,
               int'(got.segment_kind), got.anchor_x, got.anchor_y);
      error_count++;
      return;
    end
    want = expected_segments.pop_front();
    note_field("segment_kind", int'(want.segment_kind), int'(got.segment_kind));
    note_field("control_x", want.control_x, got.control_x);
    note_field("control_y", want.control_y, got.control_y);
    note_field("anchor_x", want.anchor_x, got.anchor_x);
    note_field("anchor_y", want.anchor_y, got.anchor_y);
    note_field("last_result", int'(want.last_result), int'(got.last_result));
  endtask

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall == 1'b0) begin
      check_segment(out_word);
      stall_left = draw_wait();
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end
    out_stall <= (stall_left != 0);
  end

  // Single-point contours, off-curve anchors, implied midpoints at the coordinate extremes
  // and every way a contour can be closed.
  task automatic test_directed_points();
    int hi;
    int lo;
    hi = 8388607;
    lo = -8388608;
    send_point(make_point(hi, lo, 1'b1, 1'b1));
    send_point(make_point(lo, hi, 1'b0, 1'b0));
    send_point(make_point(100, -100, 1'b1, 1'b0));
    send_point(make_point(7, 9, 1'b0, 1'b0));
    send_point(make_point(lo, lo, 1'b1, 1'b0));
    send_point(make_point(lo, hi, 1'b0, 1'b0));
    send_point(make_point(hi, lo, 1'b0, 1'b0));
    send_point(make_point(-3, 4, 1'b0, 1'b0));
    send_point(make_point(0, 0, 1'b0, 1'b1));
    send_point(make_point(0, 0, 1'b1, 1'b0));
    send_point(make_point(5, 5, 1'b0, 1'b0));
    send_point(make_point(6, -6, 1'b1, 1'b1));
    send_point(make_point(1, 1, 1'b1, 1'b0));
    send_point(make_point(2, 2, 1'b0, 1'b1));
    send_point(make_point(-1, -1, 1'b0, 1'b0));
    send_point(make_point(3, 3, 1'b1, 1'b1));
    send_point(make_point(hi, hi, 1'b0, 1'b0));
    send_point(make_point(lo, lo, 1'b0, 1'b0));
    send_point(make_point(hi, hi, 1'b0, 1'b1));
  endtask

  // Mostly complete contours of random shape, with some words of random flags mixed in.
  task automatic test_random_outlines(int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 8);
        if (len > count - sent) len = count - sent;
        for (int i = 0; i < len; i++) begin
          send_point(make_point(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)),
                                i == len - 1));
        end
        sent += len;
      end else begin
        send_point(make_point(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1))));
        sent++;
      end
    end
  endtask

  task automatic test_back_to_back(int count);
    no_idling = 1'b1;
    test_random_outlines(count);
    no_idling = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_points();
    test_random_outlines(60);
    test_back_to_back(25);
    test_random_outlines(6);
    in_valid <= 1'b0;
    while (expected_segments.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/qod_pkg.sv
sv/qod_step.sv
sv/qod_out_queue.sv
sv/quadratic_outline_decomposer_top.sv
sv/qod_checker.sv
tb/sv/tb.sv
